// File: sv/flpte_pkg.sv
// ============================================================================
// flpte_pkg
// Shared widths, command and status codes, and level index selection for the
// four-level page table engine.
// ============================================================================
package flpte_pkg;

    // Field widths
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FLAGS_W = 12;
    localparam int PAGE_W  = 40;
    localparam int ENTRY_W = 64;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // Table geometry
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int OFFSET_W          = 12;

    // Index positions of the four levels
    localparam int LVL0_SHIFT = 39;
    localparam int LVL1_SHIFT = 30;
    localparam int LVL2_SHIFT = 21;
    localparam int LVL3_SHIFT = 12;

    // Defaults
    localparam int                TABLE_FRAMES_DEF = 64;
    localparam logic [PAGE_W-1:0] BASE_PAGE_RST    = 40'd256;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNMAP     = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    // Pick the 9-bit table index of one level out of a virtual address
    function automatic logic [IDX_W-1:0] idx_of(input logic [VA_W-1:0] va,
                                                 input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        case (level)
            2'd0:    idx = va[LVL0_SHIFT +: IDX_W];
            2'd1:    idx = va[LVL1_SHIFT +: IDX_W];
            2'd2:    idx = va[LVL2_SHIFT +: IDX_W];
            default: idx = va[LVL3_SHIFT +: IDX_W];
        endcase
        return idx;
    endfunction

endpackage

// File: sv/four_level_page_table_engine.sv
// Items: the unused command goes straight to the response; translate and unmap walk
// the levels until the leaf or a missing entry; map also links a newly allocated frame
// for each missing table and then writes the leaf entry. One item at a time: the next item
// is taken in the cycle after the result is loaded, and a result waiting unaccepted holds it.
// Reset: a clearing pass writes every store entry with in_ready low; configuration
// writes are taken during the pass.
// ============================================================================
// four_level_page_table_engine
// Keeps a four-level page table in an internal store and walks it to
// translate, map and unmap 48-bit virtual addresses. Table frames come from a
// bump allocator; a frame is cleared on allocation through a per-entry epoch bit.
// ============================================================================
module four_level_page_table_engine
    import flpte_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
)(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [PAGE_W-1:0]   cfg_wdata,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [VA_W-1:0]     vaddr,
    input  logic [PA_W-1:0]     paddr,
    input  logic [FLAGS_W-1:0]  page_flags,
    // result items
    output logic                out_valid,
    input  logic                out_ready,
    output logic [PA_W-1:0]     result_addr,
    output logic [STAT_W-1:0]   status
);

    localparam int FW          = $clog2(TABLE_FRAMES);
    localparam int NW          = $clog2(TABLE_FRAMES + 1);
    localparam int AW          = FW + IDX_W;
    localparam int STORE_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int MEM_W       = ENTRY_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_ISSUE,
        S_RESP
    } state_t;

    // A frame's epoch is one once it has been allocated; entries carry the
    // epoch they were written in and read as zero when it no longer matches.
    function automatic logic epoch_of(input logic [FW-1:0] f, input logic [NW-1:0] n);
        return (f != '0) && (NW'(f) < n);
    endfunction

    state_t              state_reg, state_next;
    logic [1:0]          level_reg, level_next;
    logic [FW-1:0]       frame_reg, frame_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [PAGE_W-1:0]   pa_page_reg, pa_page_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [NW-1:0]       nf_reg, nf_next;
    logic [PAGE_W-1:0]   base_reg, base_next;
    logic [PA_W-1:0]     res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [PA_W-1:0]     out_addr_reg, out_addr_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;

    // Table store
    logic [MEM_W-1:0]    store_mem [STORE_DEPTH];
    logic [MEM_W-1:0]    mem_q_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [MEM_W-1:0]    mem_wdata;

    // Walk datapath
    logic [IDX_W-1:0]    cur_idx, nxt_idx;
    logic [ENTRY_W-1:0]  entry;
    logic                present, in_store, last_level, frames_out;
    logic [PAGE_W-1:0]   page_dist, alloc_page;
    logic [FW-1:0]       dist_frame;
    logic [NW-1:0]       nf_inc;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_addr = out_addr_reg;
    assign status      = out_status_reg;

    // Decode the entry returned by the store
    always_comb
    begin
        cur_idx    = idx_of(va_reg, level_reg);
        nxt_idx    = idx_of(va_reg, level_reg + 2'd1);
        entry      = (mem_q_reg[ENTRY_W] == epoch_of(frame_reg, nf_reg))
                     ? mem_q_reg[ENTRY_W-1:0] : '0;
        present    = entry[0];
        page_dist  = entry[OFFSET_W +: PAGE_W] - base_reg;
        in_store   = (page_dist < PAGE_W'(TABLE_FRAMES));
        dist_frame = page_dist[FW-1:0];
        last_level = (level_reg == 2'd3);
        frames_out = (nf_reg >= NW'(TABLE_FRAMES));
        nf_inc     = nf_reg + NW'(1);
        alloc_page = base_reg + PAGE_W'(nf_reg);
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        frame_next      = frame_reg;
        cmd_next        = cmd_reg;
        va_next         = va_reg;
        pa_page_next    = pa_page_reg;
        flags_next      = flags_reg;
        nf_next         = nf_reg;
        base_next       = cfg_we ? cfg_wdata : base_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        clr_cnt_next    = clr_cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = {frame_reg, cur_idx};
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = {dist_frame, nxt_idx};

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the store to zero with epoch zero
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                // Take an item and read its root entry
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    va_next         = vaddr;
                    pa_page_next    = paddr[OFFSET_W +: PAGE_W];
                    flags_next      = page_flags | FLAGS_W'(1);
                    level_next      = 2'd0;
                    frame_next      = '0;
                    res_addr_next   = '0;
                    res_status_next = ST_DONE;
                    mem_re          = 1'b1;
                    mem_raddr       = {FW'(0), idx_of(vaddr, 2'd0)};
                    if (cmd == CMD_TRANSLATE || cmd == CMD_MAP || cmd == CMD_UNMAP)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_READ:
            begin
                unique case (cmd_reg)
                    CMD_TRANSLATE:
                    begin
                        if (last_level)
                        begin
                            if (present)
                            begin
                                res_addr_next = {entry[OFFSET_W +: PAGE_W],
                                                 va_reg[OFFSET_W-1:0]};
                            end
                            else
                            begin
                                res_status_next = ST_MISS;
                            end
                            state_next = S_RESP;
                        end
                        else if (present && in_store)
                        begin
                            frame_next = dist_frame;
                            level_next = level_reg + 2'd1;
                            mem_re     = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_RESP;
                        end
                    end

                    CMD_UNMAP:
                    begin
                        if (last_level)
                        begin
                            // Drop the leaf entry
                            mem_we     = 1'b1;
                            mem_wdata  = {epoch_of(frame_reg, nf_reg), ENTRY_W'(0)};
                            state_next = S_RESP;
                        end
                        else if (present && in_store)
                        begin
                            frame_next = dist_frame;
                            level_next = level_reg + 2'd1;
                            mem_re     = 1'b1;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end

                    CMD_MAP:
                    begin
                        if (present)
                        begin
                            if (in_store)
                            begin
                                frame_next = dist_frame;
                                level_next = level_reg + 2'd1;
                                if (level_reg == 2'd2)
                                begin
                                    state_next = S_ISSUE;
                                end
                                else
                                begin
                                    mem_re = 1'b1;
                                end
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_RESP;
                            end
                        end
                        else if (frames_out)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            // Allocate a table frame and link it in
                            mem_we     = 1'b1;
                            mem_wdata  = {epoch_of(frame_reg, nf_inc),
                                          (ENTRY_W - PAGE_W - FLAGS_W)'(0),
                                          alloc_page, flags_reg};
                            nf_next    = nf_inc;
                            frame_next = nf_reg[FW-1:0];
                            level_next = level_reg + 2'd1;
                            state_next = S_ISSUE;
                        end
                    end

                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_ISSUE:
            begin
                if (cmd_reg == CMD_MAP && last_level)
                begin
                    // Write the leaf entry
                    mem_we     = 1'b1;
                    mem_wdata  = {epoch_of(frame_reg, nf_reg),
                                  (ENTRY_W - PAGE_W - FLAGS_W)'(0),
                                  pa_page_reg, flags_reg};
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {frame_reg, cur_idx};
                    state_next = S_READ;
                end
            end

            S_RESP:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            level_reg      <= '0;
            frame_reg      <= '0;
            cmd_reg        <= CMD_TRANSLATE;
            va_reg         <= '0;
            pa_page_reg    <= '0;
            flags_reg      <= '0;
            nf_reg         <= NW'(1);
            base_reg       <= BASE_PAGE_RST;
            res_addr_reg   <= '0;
            res_status_reg <= ST_DONE;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= ST_DONE;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            frame_reg      <= frame_next;
            cmd_reg        <= cmd_next;
            va_reg         <= va_next;
            pa_page_reg    <= pa_page_next;
            flags_reg      <= flags_next;
            nf_reg         <= nf_next;
            base_reg       <= base_next;
            res_addr_reg   <= res_addr_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_addr_reg   <= out_addr_next;
            out_status_reg <= out_status_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    // Table store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= store_mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg != '0) && (nf_reg <= NW'(TABLE_FRAMES)))
        else $error("frame allocator out of range");

    a_nf_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (nf_reg == $past(nf_reg) || nf_reg == $past(nf_reg) + NW'(1)))
        else $error("frame allocator moved by more than one");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_ISSUE) |-> (NW'(frame_reg) < NW'(TABLE_FRAMES)))
        else $error("walk frame outside the store");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response state");
`endif

endmodule
